FILE: sv/arpg_pkg.sv
`default_nettype none
package arpg_pkg;

    typedef logic [0:0] t_cfg_idx;
    typedef logic [1:0] t_op;

    localparam t_cfg_idx CFG_GUARD_ENABLED = 1'b0;
    localparam t_cfg_idx CFG_POLARITY      = 1'b1;

    localparam t_op OP_MARK   = 2'd1;
    localparam t_op OP_FINISH = 2'd2;

endpackage
`default_nettype wire

FILE: sv/arpg_cfg.sv
`default_nettype none
module arpg_cfg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire arpg_pkg::t_cfg_idx i_cfg_index,
    input  wire                  i_cfg_data,
    output logic                 o_guard_enabled,
    output logic                 o_polarity
);
    import arpg_pkg::*;

    logic r_guard_enabled;
    logic r_polarity;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_guard_enabled <= 1'b0;
            r_polarity      <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GUARD_ENABLED: r_guard_enabled <= i_cfg_data;
                CFG_POLARITY:      r_polarity      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_guard_enabled = r_guard_enabled;
    assign o_polarity      = r_polarity;

endmodule
`default_nettype wire

FILE: sv/arpg_nest_mem.sv
`default_nettype none
module arpg_nest_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int DW    = 8
) (
    input  wire           i_clk,
    input  wire           i_wr_en,
    input  wire  [AW-1:0] i_wr_addr,
    input  wire  [DW-1:0] i_wr_data,
    input  wire           i_rd_en,
    input  wire  [AW-1:0] i_rd_addr_a,
    input  wire  [AW-1:0] i_rd_addr_b,
    output logic [DW-1:0] o_rd_data_a,
    output logic [DW-1:0] o_rd_data_b
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_a;
    logic [DW-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule
`default_nettype wire

FILE: sv/atomic_region_preemption_guard.sv
`default_nettype none
// Scheduling events are taken when i_start is high and o_busy is low. Each event gives exactly
// one result, shown for a single cycle with o_done high; the receiver cannot stall it, so it
// must capture the result in that cycle. An event first reads the nesting counters of the
// requesting and the pending task from the counter memory, then updates them and registers the
// result. A write-back state follows when a region exit or task finish and a pending entry of
// another task both write the memory, which has a single write port. After reset the block is
// busy while the counter memory is cleared; configuration transfers are accepted at any time,
// including during that pass.
module atomic_region_preemption_guard #(
    parameter int TASKS     = 16,
    parameter int NEST_BITS = 8
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire arpg_pkg::t_cfg_idx i_cfg_index,
    input  wire               i_cfg_data,
    input  wire               i_start,
    output logic              o_busy,
    input  wire  [3:0]        i_task_req,
    input  wire arpg_pkg::t_op i_op,
    input  wire               i_region_enter,
    input  wire               i_event_readonly,
    input  wire               i_selector_undefined,
    input  wire               i_task_in_set,
    input  wire               i_skip,
    output logic              o_done,
    output logic              o_force_first,
    output logic              o_violation
);
    import arpg_pkg::*;

    localparam int AW   = $clog2(TASKS);
    localparam int ACTW = $clog2(TASKS + 1);
    localparam logic [NEST_BITS-1:0] NEST_MAX = {NEST_BITS{1'b1}};

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_WB} t_state;

    function automatic logic [AW-1:0] to_addr(input logic [3:0] t);
        logic [AW+3:0] w;
        w = {{AW{1'b0}}, t};
        return w[AW-1:0];
    endfunction

    function automatic logic in_range(input logic [3:0] t);
        return {28'd0, t} < 32'(TASKS);
    endfunction

    t_state              r_state;
    logic [AW-1:0]       r_clr_addr;
    logic [3:0]          r_task;
    t_op                 r_op;
    logic                r_enter;
    logic                r_ro;
    logic                r_sel_undef;
    logic                r_in_set;
    logic                r_skip;
    logic [ACTW-1:0]     r_active;
    logic                r_pend_valid;
    logic [3:0]          r_pend_task;
    logic                r_warn_armed;
    logic                r_warned;
    logic                r_done;
    logic                r_force;
    logic                r_viol;
    logic [AW-1:0]       r_wb_addr;
    logic [NEST_BITS-1:0] r_wb_data;

    logic                guard_enabled;
    logic                polarity;
    logic                accept;
    logic [NEST_BITS-1:0] rd_a;
    logic [NEST_BITS-1:0] rd_b;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [NEST_BITS-1:0] wr_data;

    logic                t_ok;
    logic                p_ok;
    logic                is_exit;
    logic                is_fin;
    logic                is_ent;
    logic                viol_hit;
    logic [NEST_BITS-1:0] ct2;
    logic                t_wr;
    logic [ACTW-1:0]     act1;
    logic [ACTW-1:0]     n_active;
    logic                pv1;
    logic                cur_inside;
    logic                n_warn;
    logic [NEST_BITS-1:0] pc;
    logic                p_wr;
    logic [NEST_BITS-1:0] p_data;

    arpg_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_guard_enabled (guard_enabled),
        .o_polarity      (polarity)
    );

    arpg_nest_mem #(
        .DEPTH (TASKS),
        .AW    (AW),
        .DW    (NEST_BITS)
    ) u_mem (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_en     (accept),
        .i_rd_addr_a (to_addr(i_task_req)),
        .i_rd_addr_b (to_addr(r_pend_task)),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    assign o_busy = (r_state != S_IDLE);
    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        t_ok     = in_range(r_task);
        p_ok     = in_range(r_pend_task);
        is_exit  = (r_op == OP_MARK) && !r_enter;
        is_fin   = (r_op == OP_FINISH);
        is_ent   = (r_op == OP_MARK) && r_enter;
        viol_hit = r_warn_armed && polarity && (r_active != '0) && !r_warned
                   && !(t_ok && (rd_a != '0));

        ct2  = rd_a;
        t_wr = 1'b0;
        act1 = r_active;
        pv1  = r_pend_valid;
        if (is_exit) begin
            if (t_ok && (rd_a != '0)) begin
                ct2  = rd_a - NEST_BITS'(1);
                t_wr = 1'b1;
                if ((ct2 == '0) && (r_active != '0)) begin
                    act1 = r_active - ACTW'(1);
                end
            end
            if (r_pend_task == r_task) begin
                pv1 = 1'b0;
            end
        end else if (is_fin) begin
            if (t_ok && (rd_a != '0)) begin
                ct2  = '0;
                t_wr = 1'b1;
                if (r_active != '0) begin
                    act1 = r_active - ACTW'(1);
                end
            end
            if (r_pend_task == r_task) begin
                pv1 = 1'b0;
            end
        end

        cur_inside = t_ok && (ct2 != '0);
        n_warn     = !r_ro && r_sel_undef && (cur_inside == polarity) && r_in_set && !r_skip;

        // The pending task's counter is forwarded from this event's update when both are the same.
        pc       = (r_pend_task == r_task) ? ct2 : rd_b;
        p_wr     = 1'b0;
        p_data   = pc;
        n_active = act1;
        if (pv1 && p_ok) begin
            if ((pc == '0) && (act1 < ACTW'(TASKS))) begin
                n_active = act1 + ACTW'(1);
            end
            if (pc < NEST_MAX) begin
                p_wr   = 1'b1;
                p_data = pc + NEST_BITS'(1);
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_wb_addr;
        wr_data = r_wb_data;
        case (r_state)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
            end
            S_EXEC: begin
                wr_en   = guard_enabled && (t_wr || p_wr);
                wr_addr = t_wr ? to_addr(r_task) : to_addr(r_pend_task);
                wr_data = t_wr ? ct2 : p_data;
            end
            S_WB: begin
                wr_en = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_active     <= '0;
            r_pend_valid <= 1'b0;
            r_pend_task  <= '0;
            r_warn_armed <= 1'b0;
            r_warned     <= 1'b0;
            r_done       <= 1'b0;
            r_force      <= 1'b0;
            r_viol       <= 1'b0;
        end else begin
            r_done <= (r_state == S_EXEC);
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == AW'(TASKS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_task      <= i_task_req;
                        r_op        <= i_op;
                        r_enter     <= i_region_enter;
                        r_ro        <= i_event_readonly;
                        r_sel_undef <= i_selector_undefined;
                        r_in_set    <= i_task_in_set;
                        r_skip      <= i_skip;
                        r_state     <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (guard_enabled) begin
                        r_force      <= n_warn;
                        r_viol       <= viol_hit;
                        r_warn_armed <= n_warn;
                        r_warned     <= r_warned || viol_hit;
                        r_active     <= n_active;
                        r_pend_valid <= is_ent;
                        if (is_ent) begin
                            r_pend_task <= r_task;
                        end
                        if (t_wr && p_wr) begin
                            r_wb_addr <= to_addr(r_pend_task);
                            r_wb_data <= p_data;
                            r_state   <= S_WB;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_force <= 1'b0;
                        r_viol  <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                S_WB: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done        = r_done;
    assign o_force_first = r_force;
    assign o_violation   = r_viol;

endmodule
`default_nettype wire
